// ===== rtl/core/secded_pkg.sv =====
// Shared types and constants for the 39/32 SEC-DED codec.
package secded_pkg;

  localparam int DATA_W   = 32;
  localparam int SYN_W    = 6;
  localparam int CW_BITS  = 39;
  localparam int HAM_LAST = 38;

  localparam logic [SYN_W-1:0] OVERALL_POS = 6'd39;

  // Codeword position (1-based) of each data bit, data bit 0 first.
  localparam logic [SYN_W-1:0] DATA_POS [DATA_W] = '{
    6'd3,  6'd5,  6'd6,  6'd7,  6'd9,  6'd10, 6'd11, 6'd12,
    6'd13, 6'd14, 6'd15, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd30, 6'd31, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38
  };

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_SINGLE  = 2'd1,
    ERR_DOUBLE  = 2'd2,
    ERR_OVERALL = 2'd3
  } err_class_t;

  typedef logic [CW_BITS-1:0] cw_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [SYN_W-1:0]   syn_t;

  typedef struct packed {
    kind_t kind;
    data_t data_in;
    cw_t   codeword_in;
  } in_word_t;

  typedef struct packed {
    syn_t       syndrome;
    logic       parity_odd;
    err_class_t error_class;
    syn_t       err_pos;
    logic       was_corrected;
  } dec_status_t;

  // XOR of the indices of set bits in positions 1..38.
  function automatic syn_t ham_syndrome(cw_t w);
    syn_t s;
    s = '0;
    for (int p = 1; p <= HAM_LAST; p++) begin
      if (w[p-1]) s = s ^ syn_t'(p);
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/secded_in_if.sv =====
// Input channel: one word to encode or decode.
interface secded_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [secded_pkg::DATA_W-1:0]  data_in;
  logic [secded_pkg::CW_BITS-1:0] codeword_in;

  modport source (output valid, kind, data_in, codeword_in, input ready);
  modport sink   (input valid, kind, data_in, codeword_in, output ready);
endinterface

// ===== rtl/core/secded_out_if.sv =====
// Output channel: encode or decode result word.
interface secded_out_if;
  logic                           valid;
  logic                           ready;
  logic [secded_pkg::CW_BITS-1:0] codeword_out;
  logic [secded_pkg::DATA_W-1:0]  data_out;
  logic [secded_pkg::SYN_W-1:0]   syndrome;
  logic                           parity_odd;
  logic [1:0]                     error_class;
  logic [secded_pkg::SYN_W-1:0]   err_pos;
  logic                           was_corrected;

  modport source (output valid, codeword_out, data_out, syndrome, parity_odd,
                  error_class, err_pos, was_corrected, input ready);
  modport sink   (input valid, codeword_out, data_out, syndrome, parity_odd,
                  error_class, err_pos, was_corrected, output ready);
endinterface

// ===== rtl/core/secded_enc.sv =====
// Hamming encoder: 32 data bits to a 39-bit codeword.
module secded_enc (
  input  secded_pkg::data_t data,
  output secded_pkg::cw_t   codeword
);
  import secded_pkg::*;

  cw_t  placed;
  cw_t  with_par;
  syn_t syn;

  always_comb begin
    placed = '0;
    for (int i = 0; i < DATA_W; i++) begin
      placed[DATA_POS[i] - 6'd1] = data[i];
    end
  end

  assign syn = ham_syndrome(placed);

  // Each check bit sits at a power-of-two position, so it cancels its own syndrome bit.
  always_comb begin
    with_par = placed;
    for (int i = 0; i < SYN_W; i++) begin
      with_par[(1 << i) - 1] = syn[i];
    end
    with_par[CW_BITS-1] = ^with_par[HAM_LAST-1:0];
  end

  assign codeword = with_par;

endmodule

// ===== rtl/core/secded_dec.sv =====
// Hamming decoder: syndrome, error class, correction and data extraction.
module secded_dec (
  input  secded_pkg::cw_t         codeword,
  output secded_pkg::data_t       data,
  output secded_pkg::dec_status_t status
);
  import secded_pkg::*;

  syn_t syn;
  logic odd;
  cw_t  fixed;

  assign syn = ham_syndrome(codeword);
  assign odd = ^codeword;

  always_comb begin
    fixed                 = codeword;
    status.syndrome       = syn;
    status.parity_odd     = odd;
    status.error_class    = ERR_NONE;
    status.err_pos        = '0;
    status.was_corrected  = 1'b0;
    priority if (syn == '0 && odd) begin
      status.error_class    = ERR_OVERALL;
      status.err_pos        = OVERALL_POS;
      status.was_corrected  = 1'b1;
      fixed[CW_BITS-1]      = ~codeword[CW_BITS-1];
    end else if (syn != '0 && odd) begin
      status.error_class    = ERR_SINGLE;
      status.err_pos        = syn;
      // Syndromes past the last Hamming position name no Hamming bit and are left uncorrected.
      if (syn <= syn_t'(HAM_LAST)) begin
        fixed[syn - 6'd1]    = ~codeword[syn - 6'd1];
        status.was_corrected = 1'b1;
      end
    end else if (syn != '0) begin
      status.error_class = ERR_DOUBLE;
    end else begin
      status.error_class = ERR_NONE;
    end
  end

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      data[i] = fixed[DATA_POS[i] - 6'd1];
    end
  end

endmodule

// ===== rtl/core/secded_39_32_codec.sv =====
// SEC-DED 39/32 codec top: input register, encode/decode logic, result register.
// Result path: input register, then result register; a stalled output holds the result register.
// Throughput: one word per cycle; both stages advance together whenever
//   the result register is empty or being drained.
// Reset (rst, synchronous, active high) empties both stages; payload regs are not reset.
// No configuration and no state carries over between words.
module secded_39_32_codec (
  input logic         clk,
  input logic         rst,
  secded_in_if.sink   req,
  secded_out_if.source rsp
);
  import secded_pkg::*;

  // Stage 1: captured input word
  logic     s1_valid;
  in_word_t s1;

  // Stage 2: result register
  logic        out_valid;
  cw_t         out_cw;
  data_t       out_data;
  dec_status_t out_stat;

  // Combinational results from the stage 1 word
  cw_t         enc_cw;
  data_t       dec_data;
  dec_status_t dec_stat;

  logic adv;     // result register can take a new word this cycle
  logic s1_load; // input register takes a new word this cycle

  assign adv     = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || adv;
  assign s1_load = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load || adv) begin
      s1_valid <= s1_load;
    end
    if (s1_load) begin
      s1.kind        <= kind_t'(req.kind);
      s1.data_in     <= req.data_in;
      s1.codeword_in <= req.codeword_in;
    end
  end

  secded_enc u_enc (
    .data     (s1.data_in),
    .codeword (enc_cw)
  );

  secded_dec u_dec (
    .codeword (s1.codeword_in),
    .data     (dec_data),
    .status   (dec_stat)
  );

  // Fields that don't belong to the word's kind read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
    if (adv && s1_valid) begin
      unique case (s1.kind)
        KIND_ENCODE: begin
          out_cw   <= enc_cw;
          out_data <= '0;
          out_stat <= '{syndrome: '0, parity_odd: 1'b0, error_class: ERR_NONE,
                        err_pos: '0, was_corrected: 1'b0};
        end
        KIND_DECODE: begin
          out_cw   <= '0;
          out_data <= dec_data;
          out_stat <= dec_stat;
        end
        default: begin
          out_cw   <= '0;
          out_data <= '0;
          out_stat <= '0;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.codeword_out   = out_cw;
  assign rsp.data_out       = out_data;
  assign rsp.syndrome       = out_stat.syndrome;
  assign rsp.parity_odd     = out_stat.parity_odd;
  assign rsp.error_class    = out_stat.error_class;
  assign rsp.err_pos        = out_stat.err_pos;
  assign rsp.was_corrected  = out_stat.was_corrected;

  // Both stages come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  // A word handed from stage 1 shows up in the result register next cycle.
  a_stage_handoff: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv) |=> out_valid)
    else $error("stage 1 word lost on handoff");

  // Only single or overall-parity errors can be flipped back.
  a_corr_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stat.was_corrected) |->
      (out_stat.error_class == ERR_SINGLE || out_stat.error_class == ERR_OVERALL))
    else $error("correction flagged for uncorrectable class");

  // Clean and double-error results carry no position and no correction.
  a_no_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_stat.error_class == ERR_NONE ||
                   out_stat.error_class == ERR_DOUBLE)) |->
      (out_stat.err_pos == '0 && !out_stat.was_corrected))
    else $error("position or correction set without a correctable error");

endmodule
